@@ hw/rtl/closed_quadratic_bspline_sampler_unit_assert.svh @@
// assertion macros shared by the sampler rtl
`ifndef CLOSED_QUADRATIC_BSPLINE_SAMPLER_UNIT_ASSERT_SVH
`define CLOSED_QUADRATIC_BSPLINE_SAMPLER_UNIT_ASSERT_SVH

// same-cycle implication, disabled during reset
`define CQBS_CHK(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled during reset
`define CQBS_CHK_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ hw/rtl/cqbs_pkg.sv @@
// shared constants, weight table and types of the b-spline sampler
`timescale 1ns / 1ps

package cqbs_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int SAMPLES        = 5;
    localparam int K_W            = $clog2(SAMPLES);
    localparam int QUEUE_DEPTH    = 2;
    localparam int DIVISOR        = 50;
    localparam int ROUND_HALF     = 25;

    typedef logic [5:0] t_wt;

    // per-sample weights of the older, middle and newer point, over 50
    localparam t_wt WT [0:SAMPLES-1][0:2] = '{
        '{6'd25, 6'd25, 6'd0},
        '{6'd16, 6'd33, 6'd1},
        '{6'd9,  6'd37, 6'd4},
        '{6'd4,  6'd37, 6'd9},
        '{6'd1,  6'd33, 6'd16}
    };

    // what a held control point turns into
    typedef enum logic [2:0] {
        KIND_FILL,
        KIND_OPEN,
        KIND_LONE,
        KIND_PAIR,
        KIND_CLOSE
    } t_kind;

endpackage

@@ hw/rtl/closed_quadratic_bspline_sampler_unit.sv @@
// top level of the closed uniform quadratic b-spline sampler
//
//  channel   direction  handshake           beat contents
//  point     in         i_valid / o_stall   i_point_x, i_point_y, i_final_point
//  curve     out        o_valid / i_stall   o_curve_x, o_curve_y, o_curve_end
//
// a point that opens a segment issues one segment, the final point one, two or three
// segments; the first two points of a polygon, unless final, issue none
// the back end emits one sample per cycle while i_stall is low; a taken point passes the
// front register, the segment queue, the segment register and three register stages
// reset is synchronous, active low, and clears the polygon state and all valids
// a two-entry segment queue lets the front keep taking points while i_stall holds the back
`timescale 1ns / 1ps

module closed_quadratic_bspline_sampler_unit #(
    parameter int COORD_BITS = cqbs_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_final_point,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_curve_x,
    output logic signed [COORD_BITS-1:0] o_curve_y,
    output logic                         o_curve_end
);

    localparam int SEG_W = 6 * COORD_BITS + 1;

    logic             push;
    logic             full;
    logic             pop;
    logic             empty;
    logic [SEG_W-1:0] seg_in;
    logic [SEG_W-1:0] seg_out;

    cqbs_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_point_x     (i_point_x),
        .i_point_y     (i_point_y),
        .i_final_point (i_final_point),
        .o_push        (push),
        .o_seg         (seg_in),
        .i_full        (full)
    );

    cqbs_queue #(
        .W     (SEG_W),
        .DEPTH (cqbs_pkg::QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_data  (seg_in),
        .o_full  (full),
        .i_pop   (pop),
        .o_data  (seg_out),
        .o_empty (empty)
    );

    cqbs_back #(
        .COORD_BITS (COORD_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_seg       (seg_out),
        .i_seg_vld   (!empty),
        .o_pop       (pop),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_curve_x   (o_curve_x),
        .o_curve_y   (o_curve_y),
        .o_curve_end (o_curve_end)
    );

endmodule

@@ hw/rtl/cqbs_front.sv @@
// front end: takes control points, tracks polygon state, issues segments
`timescale 1ns / 1ps
`include "closed_quadratic_bspline_sampler_unit_assert.svh"

module cqbs_front #(
    parameter int COORD_BITS = cqbs_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic signed [COORD_BITS-1:0] i_point_x,
    input  logic signed [COORD_BITS-1:0] i_point_y,
    input  logic                         i_final_point,
    output logic                         o_push,
    output logic [6*COORD_BITS:0]        o_seg,
    input  logic                         i_full
);

    localparam int PT_W = 2 * COORD_BITS;

    logic              r_busy;
    logic              r_fin;
    logic [1:0]        r_idx;
    logic [1:0]        r_seen;
    logic [PT_W-1:0]   r_p;
    logic [PT_W-1:0]   r_first;
    logic [PT_W-1:0]   r_second;
    logic [PT_W-1:0]   r_older;
    logic [PT_W-1:0]   r_newer;

    cqbs_pkg::t_kind   kind;
    logic [1:0]        idx_last;
    logic              fill;
    logic              done;
    logic              accept;
    logic [PT_W-1:0]   seg_a;
    logic [PT_W-1:0]   seg_b;
    logic [PT_W-1:0]   seg_c;
    logic              seg_last;

    // state is updated only when the held point retires, so it is current here
    always_comb begin
        priority if (r_fin && r_seen == 2'd0) begin
            kind = cqbs_pkg::KIND_LONE;
        end else if (r_fin && r_seen == 2'd1) begin
            kind = cqbs_pkg::KIND_PAIR;
        end else if (r_fin) begin
            kind = cqbs_pkg::KIND_CLOSE;
        end else if (r_seen >= 2'd2) begin
            kind = cqbs_pkg::KIND_OPEN;
        end else begin
            kind = cqbs_pkg::KIND_FILL;
        end
    end

    always_comb begin
        seg_a    = r_p;
        seg_b    = r_p;
        seg_c    = r_p;
        seg_last = 1'b0;
        idx_last = 2'd0;
        unique case (kind)
            cqbs_pkg::KIND_LONE: begin
                seg_last = 1'b1;
            end
            cqbs_pkg::KIND_PAIR: begin
                idx_last = 2'd1;
                if (r_idx == 2'd0) begin
                    seg_a = r_first;
                    seg_c = r_first;
                end else begin
                    seg_b    = r_first;
                    seg_last = 1'b1;
                end
            end
            cqbs_pkg::KIND_CLOSE: begin
                idx_last = 2'd2;
                if (r_idx == 2'd0) begin
                    seg_a = r_older;
                    seg_b = r_newer;
                end else if (r_idx == 2'd1) begin
                    seg_a = r_newer;
                    seg_c = r_first;
                end else begin
                    seg_b    = r_first;
                    seg_c    = r_second;
                    seg_last = 1'b1;
                end
            end
            cqbs_pkg::KIND_OPEN, cqbs_pkg::KIND_FILL: begin
                seg_a = r_older;
                seg_b = r_newer;
            end
            default: begin
                seg_last = 1'b0;
            end
        endcase
    end

    assign fill    = (kind == cqbs_pkg::KIND_FILL);
    assign o_push  = r_busy && !fill && !i_full;
    assign done    = r_busy && (fill || (o_push && r_idx == idx_last));
    assign o_stall = r_busy && !done;
    assign accept  = i_valid && !o_stall;
    assign o_seg   = {seg_a, seg_b, seg_c, seg_last};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy   <= 1'b0;
            r_fin    <= 1'b0;
            r_idx    <= 2'd0;
            r_p      <= '0;
        end else if (accept) begin
            r_busy   <= 1'b1;
            r_fin    <= i_final_point;
            r_idx    <= 2'd0;
            r_p      <= {i_point_x, i_point_y};
        end else if (done) begin
            r_busy   <= 1'b0;
        end else if (o_push) begin
            r_idx    <= r_idx + 2'd1;
        end
    end

    // polygon state advances when the held point retires
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seen   <= 2'd0;
            r_first  <= '0;
            r_second <= '0;
            r_older  <= '0;
            r_newer  <= '0;
        end else if (done) begin
            if (r_fin) begin
                r_seen   <= 2'd0;
                r_first  <= '0;
                r_second <= '0;
                r_older  <= '0;
                r_newer  <= '0;
            end else begin
                if (r_seen == 2'd0) begin
                    r_first <= r_p;
                    r_seen  <= 2'd1;
                end else if (r_seen == 2'd1) begin
                    r_second <= r_p;
                    r_seen   <= 2'd2;
                end
                r_older <= r_newer;
                r_newer <= r_p;
            end
        end
    end

    `CQBS_CHK(a_seen_sat, i_clk, i_rst_n, 1'b1, r_seen != 2'd3, "point count past saturation")
    `CQBS_CHK(a_idx_range, i_clk, i_rst_n, r_busy && !fill, r_idx <= idx_last, "segment index overrun")

endmodule

@@ hw/rtl/cqbs_queue.sv @@
// short segment queue between front and back
`timescale 1ns / 1ps
`include "closed_quadratic_bspline_sampler_unit_assert.svh"

module cqbs_queue #(
    parameter int W     = 97,
    parameter int DEPTH = cqbs_pkg::QUEUE_DEPTH
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    output logic         o_full,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [W-1:0]     r_mem [0:DEPTH-1];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_count;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    assign o_full  = (r_count == CNT_W'(DEPTH));
    assign o_empty = (r_count == '0);
    assign o_data  = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= ptr_inc(r_wr);
            end
            if (i_pop) begin
                r_rd <= ptr_inc(r_rd);
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + CNT_W'(1);
            end else if (i_pop && !i_push) begin
                r_count <= r_count - CNT_W'(1);
            end
        end
    end

    `CQBS_CHK(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= CNT_W'(DEPTH), "queue count overflow")
    `CQBS_CHK(a_q_pop, i_clk, i_rst_n, i_pop, r_count != '0, "pop from empty queue")

endmodule

@@ hw/rtl/cqbs_back.sv @@
// back end: five samples per segment, weighted sums, round-divide by 50 through a reciprocal
`timescale 1ns / 1ps
`include "closed_quadratic_bspline_sampler_unit_assert.svh"

module cqbs_back #(
    parameter int COORD_BITS = cqbs_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic [6*COORD_BITS:0]        i_seg,
    input  logic                         i_seg_vld,
    output logic                         o_pop,
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic signed [COORD_BITS-1:0] o_curve_x,
    output logic signed [COORD_BITS-1:0] o_curve_y,
    output logic                         o_curve_end
);

    localparam int CB    = COORD_BITS;
    localparam int SEG_W = 6 * CB + 1;
    localparam int PT_W  = 2 * CB;
    localparam int PW    = CB + 7;
    localparam int TW    = CB + 6;
    localparam int MW    = CB + 7;
    localparam int SH    = CB + 12;
    localparam int QW    = SH + CB;
    localparam int K_W   = cqbs_pkg::K_W;
    localparam logic [K_W-1:0] K_LAST = K_W'(cqbs_pkg::SAMPLES - 1);
    // +25 rounds, +50*2^(CB-1) makes the dividend non-negative
    localparam logic [PW-1:0] ROUND_OFFS =
        (PW'(cqbs_pkg::DIVISOR) << (CB - 1)) + PW'(cqbs_pkg::ROUND_HALF);
    // ceil(2^SH / 50), exact floor quotient for any dividend below 2^TW
    localparam logic [MW-1:0] RECIP =
        MW'(((longint'(1) << SH) + longint'(cqbs_pkg::DIVISOR - 1))
            / longint'(cqbs_pkg::DIVISOR));

    // sequencer
    logic [SEG_W-1:0] r_seg;
    logic             r_seg_vld;
    logic [K_W-1:0]   r_k;
    logic             adv;
    logic             take;
    logic             seg_done;

    // product stage
    logic                 r_p_vld;
    logic                 r_p_last;
    logic signed [PW-1:0] r_px [0:2];
    logic signed [PW-1:0] r_py [0:2];
    logic signed [PW-1:0] n_px [0:2];
    logic signed [PW-1:0] n_py [0:2];
    logic signed [CB-1:0] cx   [0:2];
    logic signed [CB-1:0] cy   [0:2];
    logic signed [PW-1:0] wv   [0:2];

    // offset sum stage
    logic          r_t_vld;
    logic          r_t_last;
    logic [TW-1:0] r_t_x;
    logic [TW-1:0] r_t_y;
    logic [PW-1:0] n_sum_x;
    logic [PW-1:0] n_sum_y;

    // quotient stage
    logic          r_q_vld;
    logic          r_q_last;
    logic [CB-1:0] r_q_x;
    logic [CB-1:0] r_q_y;
    logic [QW-1:0] n_prod_x;
    logic [QW-1:0] n_prod_y;

    assign adv      = !r_q_vld || !i_stall;
    assign take     = adv && r_seg_vld;
    assign seg_done = take && (r_k == K_LAST);
    assign o_pop    = i_seg_vld && (!r_seg_vld || seg_done);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seg_vld <= 1'b0;
            r_k       <= '0;
        end else if (o_pop) begin
            r_seg_vld <= 1'b1;
            r_k       <= '0;
        end else if (seg_done) begin
            r_seg_vld <= 1'b0;
        end else if (take) begin
            r_k       <= r_k + K_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_seg <= i_seg;
        end
    end

    // segment layout: {a, b, c, last}, each point {x, y}
    always_comb begin
        for (int j = 0; j < 3; j++) begin
            cx[j]   = r_seg[1 + (2 - j) * PT_W + CB +: CB];
            cy[j]   = r_seg[1 + (2 - j) * PT_W +: CB];
            wv[j]   = PW'($signed({1'b0, cqbs_pkg::WT[r_k][j]}));
            n_px[j] = PW'(cx[j]) * wv[j];
            n_py[j] = PW'(cy[j]) * wv[j];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
        end else if (adv) begin
            r_p_vld <= take;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_p_last <= r_seg[0] && (r_k == K_LAST);
            for (int j = 0; j < 3; j++) begin
                r_px[j] <= n_px[j];
                r_py[j] <= n_py[j];
            end
        end
    end

    assign n_sum_x = r_px[0] + r_px[1] + r_px[2] + ROUND_OFFS;
    assign n_sum_y = r_py[0] + r_py[1] + r_py[2] + ROUND_OFFS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_t_vld <= 1'b0;
        end else if (adv) begin
            r_t_vld <= r_p_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_t_last <= r_p_last;
            r_t_x    <= n_sum_x[TW-1:0];
            r_t_y    <= n_sum_y[TW-1:0];
        end
    end

    assign n_prod_x = QW'(r_t_x) * QW'(RECIP);
    assign n_prod_y = QW'(r_t_y) * QW'(RECIP);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q_vld <= 1'b0;
        end else if (adv) begin
            r_q_vld <= r_t_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_q_last <= r_t_last;
            r_q_x    <= n_prod_x[SH +: CB];
            r_q_y    <= n_prod_y[SH +: CB];
        end
    end

    // removing the 2^(CB-1) bias is a flip of the top quotient bit
    assign o_valid     = r_q_vld;
    assign o_curve_end = r_q_last;
    assign o_curve_x   = $signed({~r_q_x[CB-1], r_q_x[CB-2:0]});
    assign o_curve_y   = $signed({~r_q_y[CB-1], r_q_y[CB-2:0]});

    `CQBS_CHK(a_k_range, i_clk, i_rst_n, r_seg_vld, r_k <= K_LAST, "sample counter overrun")
    `CQBS_CHK_NEXT(a_seg_wrap, i_clk, i_rst_n, seg_done, !r_seg_vld || r_k == '0, "segment not retired")

endmodule

@@ dv/tb.sv @@
// testbench of the closed quadratic b-spline sampler with its own sample predictor
`timescale 1ns / 1ps

module tb;

    localparam int CB           = cqbs_pkg::COORD_BITS_DEF;
    localparam int RANDOM_ITEMS = 84;
    localparam int HOLD_CYCLES  = 300;
    localparam int SETTLE       = CB + 20;
    localparam int STALL_LIMIT  = 4000;

    typedef logic signed [CB-1:0] t_coord;

    typedef struct {
        t_coord x;
        t_coord y;
    } t_point;

    typedef struct {
        t_coord x;
        t_coord y;
        logic   last;
    } t_curve_beat;

    // spline weights of the older, middle and newer point, over 50
    localparam int SPLINE_WT [5][3] = '{
        '{25, 25, 0}, '{16, 33, 1}, '{9, 37, 4}, '{4, 37, 9}, '{1, 33, 16}
    };

    class curve_scoreboard;
        t_point      first_pt;
        t_point      second_pt;
        t_point      older_pt;
        t_point      newer_pt;
        int unsigned taken;
        t_curve_beat curve_q[$];
        int          errors;

        function new();
            clear_polygon();
            errors = 0;
        endfunction

        function void clear_polygon();
            first_pt  = '{0, 0};
            second_pt = '{0, 0};
            older_pt  = '{0, 0};
            newer_pt  = '{0, 0};
            taken     = 0;
        endfunction

        // weighted sum over 50, rounded half up, clamped to the coordinate range
        function t_coord blend(int k, t_coord a, t_coord b, t_coord c);
            longint s;
            longint q;
            longint r;
            longint hi;
            hi = (longint'(1) <<< (CB - 1)) - 1;
            s = SPLINE_WT[k][0] * longint'(a) + SPLINE_WT[k][1] * longint'(b)
                + SPLINE_WT[k][2] * longint'(c);
            q = s + 25;
            r = (q >= 0) ? q / 50 : -((-q + 49) / 50);
            if (r > hi) r = hi;
            if (r < -hi - 1) r = -hi - 1;
            return t_coord'(r);
        endfunction

        function void push_segment(t_point a, t_point b, t_point c, bit closes);
            t_curve_beat beat;
            for (int k = 0; k < 5; k++) begin
                beat.x    = blend(k, a.x, b.x, c.x);
                beat.y    = blend(k, a.y, b.y, c.y);
                beat.last = closes && (k == 4);
                curve_q.insert(curve_q.size(), beat);
            end
        endfunction

        function void note_point(t_coord x, t_coord y, logic fin);
            t_point p;
            p = '{x, y};
            if (fin) begin
                if (taken == 0) begin
                    push_segment(p, p, p, 1'b1);
                end else if (taken == 1) begin
                    push_segment(first_pt, p, first_pt, 1'b0);
                    push_segment(p, first_pt, p, 1'b1);
                end else begin
                    push_segment(older_pt, newer_pt, p, 1'b0);
                    push_segment(newer_pt, p, first_pt, 1'b0);
                    push_segment(p, first_pt, second_pt, 1'b1);
                end
                clear_polygon();
                return;
            end
            if (taken == 0) begin
                first_pt = p;
                taken    = 1;
            end else if (taken == 1) begin
                second_pt = p;
                taken     = 2;
            end else begin
                push_segment(older_pt, newer_pt, p, 1'b0);
            end
            older_pt = newer_pt;
            newer_pt = p;
        endfunction

        function void check_sample(t_coord x, t_coord y, logic last);
            t_curve_beat want;
            if (curve_q.size() == 0) begin
                $error("curve beat with nothing expected: x %0d y %0d end %0b", x, y, last);
                errors++;
                return;
            end
            want = curve_q.pop_front();
            if (x !== want.x) begin
                $error("curve_x expected %0d got %0d", want.x, x);
                errors++;
            end
            if (y !== want.y) begin
                $error("curve_y expected %0d got %0d", want.y, y);
                errors++;
            end
            if (last !== want.last) begin
                $error("curve_end expected %0b got %0b", want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic   i_clk;
    logic   i_rst_n;
    logic   i_valid;
    logic   o_stall;
    t_coord i_point_x;
    t_coord i_point_y;
    logic   i_final_point;
    logic   o_valid;
    logic   i_stall;
    t_coord o_curve_x;
    t_coord o_curve_y;
    logic   o_curve_end;

    curve_scoreboard sb = new();

    bit idle_on     = 1'b1;
    bit hold_req    = 1'b0;
    bit hold_served = 1'b0;
    int quiet_cycles = 0;
    int points_sent  = 0;

    closed_quadratic_bspline_sampler_unit #(.COORD_BITS(CB)) DUT (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_point_x    (i_point_x),
        .i_point_y    (i_point_y),
        .i_final_point(i_final_point),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_curve_x    (o_curve_x),
        .o_curve_y    (o_curve_y),
        .o_curve_end  (o_curve_end)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // both channels sampled at the edge, inputs noted before outputs are checked
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall) sb.note_point(i_point_x, i_point_y, i_final_point);
            if (o_valid && !i_stall) sb.check_sample(o_curve_x, o_curve_y, o_curve_end);
        end
    end

    always @(posedge i_clk) begin
        if ((i_valid && !o_stall) || (o_valid && !i_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // curve receiver: random stalls, plus one long hold-off on request
    initial begin
        i_stall <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_req && !hold_served) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge i_clk);
                hold_served = 1'b1;
            end else begin
                i_stall <= idle_on && ($urandom_range(99) < 36);
            end
        end
    end

    task automatic offer_point(t_coord x, t_coord y, logic fin);
        while (idle_on && $urandom_range(99) < 36) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid       <= 1'b1;
        i_point_x     <= x;
        i_point_y     <= y;
        i_final_point <= fin;
        do @(posedge i_clk); while (o_stall);
        points_sent++;
    endtask

    task automatic wait_curve_drained();
        i_valid <= 1'b0;
        while (sb.curve_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_coord pick_coord();
        case ($urandom_range(9))
            0:       return t_coord'({1'b0, {(CB-1){1'b1}}});
            1:       return t_coord'({1'b1, {(CB-1){1'b0}}});
            2:       return t_coord'(int'($urandom_range(200)) - 100);
            default: return t_coord'($urandom);
        endcase
    endfunction

    initial begin
        t_coord      cmax;
        t_coord      cmin;
        int unsigned poly_len;
        bit          mid_drained;

        cmax = {1'b0, {(CB-1){1'b1}}};
        cmin = {1'b1, {(CB-1){1'b0}}};
        mid_drained = 1'b0;

        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_point_x     <= '0;
        i_point_y     <= '0;
        i_final_point <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // one-point polygons
        offer_point(cmax, cmin, 1'b1);
        offer_point('0, '0, 1'b1);
        // two-point polygon
        offer_point(cmin, cmax, 1'b0);
        offer_point(cmax, cmin, 1'b1);
        // three-point polygon
        offer_point(16'sd1000, -16'sd2000, 1'b0);
        offer_point(-16'sd3000, 16'sd4000, 1'b0);
        offer_point(16'sd5000, 16'sd6001, 1'b1);
        // rounding ties on both signs
        offer_point(16'sd1, -16'sd1, 1'b0);
        offer_point('0, '0, 1'b0);
        offer_point(-16'sd1, 16'sd1, 1'b0);
        offer_point(16'sd1, 16'sd1, 1'b1);
        // corner to corner swings
        offer_point(cmax, cmax, 1'b0);
        offer_point(cmin, cmin, 1'b0);
        offer_point(cmax, cmin, 1'b0);
        offer_point(cmin, cmax, 1'b0);
        offer_point(cmax, cmax, 1'b0);
        offer_point(cmin, cmin, 1'b1);
        wait_curve_drained();

        points_sent = 0;
        while (points_sent < RANDOM_ITEMS) begin
            idle_on  = !(points_sent >= 30 && points_sent < 60);
            poly_len = ($urandom_range(9) < 2) ? $urandom_range(1, 2)
                                               : $urandom_range(3, 9);
            if (points_sent >= 70) hold_req = 1'b1;
            for (int unsigned k = 1; k <= poly_len; k++) begin
                offer_point(pick_coord(), pick_coord(), k == poly_len);
            end
            if (points_sent >= 50 && !mid_drained) begin
                wait_curve_drained();
                mid_drained = 1'b1;
            end
        end

        wait_curve_drained();
        repeat (SETTLE) @(posedge i_clk);
        if (sb.curve_q.size() != 0) begin
            $error("%0d curve beats never arrived", sb.curve_q.size());
            sb.errors++;
        end
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
